### rtl/core/lzwz_pkg.sv
// Package for the .Z LZW decoder: state enum, word types, status codes,
// command codes and table constants. No dependencies.
package lzwz_pkg;

   localparam int unsigned LITERALS   = 256;
   localparam int unsigned FIRST_FREE = 257;
   localparam int unsigned INIT_WIDTH = 9;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NEED_IN  = 3'd1;
   localparam logic [2:0] ST_REJECT   = 3'd2;
   localparam logic [2:0] ST_FINISHED = 3'd3;
   localparam logic [2:0] ST_ERROR    = 3'd4;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_PULL = 1'b1;

   localparam logic [1:0] REG_MAX_BITS   = 2'd0;
   localparam logic [1:0] REG_BLOCK_MODE = 2'd1;
   localparam logic [1:0] REG_SKIP_COUNT = 2'd2;
   localparam logic [1:0] REG_OUT_COUNT  = 2'd3;

   typedef struct packed {
      logic       cmd;
      logic [7:0] in_byte;
      logic       in_last;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic [2:0] status;
   } rsp_word_type;

   typedef enum logic [3:0] {
      S_INIT,      // fill literal suffix entries
      S_IDLE,
      S_PULL_RD,   // stack read issued
      S_DECODE,    // code extracted, classify
      S_WALK_RD,   // table read issued for chain entry
      S_WALK,      // push suffix, follow prefix
      S_FINISH,    // write new entry, update width
      S_RESP
   } state_type;

endpackage

### rtl/core/lzwz_stream_if.sv
// Valid/ready channel interface carrying one word of payload type T.
// Depends on nothing.
interface lzwz_stream_if #(parameter type T = logic) ();
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/lzwz_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// Depends on nothing.
module lzwz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### rtl/core/lzw_compress_z_decoder.sv
// .Z LZW body decoder: push compressed words, pull decoded words.
// Steps per word: a pull of a held byte goes idle, stack read, response; a push that
// completes no code goes straight to the response; a first code, CLEAR or bad code
// goes via decode; a push that expands a code walks the chain (a table read and a
// walk step per entry, literal too), then writes the new entry. One word at a time.
// After reset the literal suffix entries are written first. Reset: synchronous, active high.
module lzw_compress_z_decoder
   import lzwz_pkg::*;
#(
   parameter int MAX_CODE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   lzwz_stream_if.sink   req,
   lzwz_stream_if.source rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int TSIZE = 1 << MAX_CODE_BITS;
   localparam int AW    = MAX_CODE_BITS;
   localparam int CW    = MAX_CODE_BITS + 1;   // code/count width incl. TSIZE

   // request payload: {cmd, in_byte, in_last}; response: {out_byte, out_valid, status}
   state_type state_ff, state_in;

   logic [4:0]  max_bits_ff, max_bits_in;
   logic        block_mode_ff, block_mode_in;
   logic [31:0] skip_left_ff, deliver_left_ff;

   logic [CW-1:0] stack_depth_ff, stack_depth_in;
   logic [23:0]   bit_buffer_ff, bit_buffer_in;
   logic [4:0]    bits_held_ff, bits_held_in;
   logic [4:0]    group_seen_ff, group_seen_in;
   logic [4:0]    discard_ff, discard_in;
   logic [4:0]    code_width_ff, code_width_in;
   logic [CW-1:0] next_free_ff, next_free_in;
   logic [AW-1:0] prev_code_ff, prev_code_in;
   logic [7:0]    first_char_ff, first_char_in;
   logic          f_first_ff, f_first_in, f_clear_ff, f_clear_in;
   logic          f_end_ff, f_end_in, f_err_ff, f_err_in;
   logic [CW-1:0] code_ff, code_in;       // current code being decoded
   logic [AW-1:0] walk_ff, walk_in;       // chain pointer
   logic [CW-1:0] depth_ff, depth_in;     // walk depth
   logic [8:0]    init_ff, init_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [31:0]   skip_in, deliver_in;

   // RAM ports
   logic          pre_we, suf_we, stk_we;
   logic [AW-1:0] pre_wa, suf_wa, stk_wa, pre_ra, suf_ra, stk_ra;
   logic [AW-1:0] pre_wd, pre_rd;
   logic [7:0]    suf_wd, suf_rd, stk_wd, stk_rd;

   lzwz_ram #(.WIDTH(AW), .DEPTH(TSIZE)) u_prefix (
      .clock, .wr_en(pre_we), .wr_addr(pre_wa), .wr_data(pre_wd),
      .rd_addr(pre_ra), .rd_data(pre_rd));
   lzwz_ram #(.WIDTH(8), .DEPTH(TSIZE)) u_suffix (
      .clock, .wr_en(suf_we), .wr_addr(suf_wa), .wr_data(suf_wd),
      .rd_addr(suf_ra), .rd_data(suf_rd));
   lzwz_ram #(.WIDTH(8), .DEPTH(TSIZE)) u_stack (
      .clock, .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_addr(stk_ra), .rd_data(stk_rd));

   logic        cmd, last;
   logic [7:0]  in_b;
   assign cmd  = req.data.cmd;
   assign in_b = req.data.in_byte;
   assign last = req.data.in_last;

   logic accept;
   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign rsp.valid = (state_ff == S_RESP);
   assign rsp.data.out_byte  = rsp_byte_ff;
   assign rsp.data.out_valid = rsp_valid_ff;
   assign rsp.data.status    = rsp_status_ff;

   // derived values
   logic [CW:0]   maxmax;
   logic          bad_bits;
   logic [4:0]    limit;
   logic [31:0]   shifted;
   logic [5:0]    held_sum;
   logic [CW-1:0] code_mask;
   assign maxmax    = (CW+1)'(1) << max_bits_ff;
   assign bad_bits  = max_bits_ff > 5'(MAX_CODE_BITS);
   assign limit     = (max_bits_ff < 5'd10) ? 5'd10 : max_bits_ff;
   assign shifted   = {8'd0, bit_buffer_ff} | ({24'd0, in_b} << bits_held_ff);
   assign held_sum  = {1'b0, bits_held_ff} + 6'd8;
   assign code_mask = CW'(((CW+1)'(1) << code_width_ff) - 1'b1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT:    if (init_ff == 9'd255) state_in = S_IDLE;
         S_IDLE:    if (accept) begin
            priority if (bad_bits || f_err_ff || deliver_left_ff == 32'd0)
               state_in = S_RESP;
            else if (cmd == CMD_PULL)
               state_in = (stack_depth_ff != '0) ? S_PULL_RD : S_RESP;
            else if (stack_depth_ff != '0 || f_end_ff || discard_ff != '0
                     || held_sum < {1'b0, code_width_ff})
               state_in = S_RESP;
            else
               state_in = S_DECODE;
         end
         S_PULL_RD: state_in = S_RESP;
         S_DECODE:  state_in = S_WALK_RD;  // refined in state_q block
         S_WALK_RD: state_in = S_WALK;
         S_WALK:    state_in = S_WALK_RD;  // refined in state_q block
         S_FINISH:  state_in = S_RESP;
         S_RESP:    if (rsp.ready) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   logic [2:0]  st_sel;
   logic        goto_finish, goto_resp;

   always_comb begin
      stack_depth_in = stack_depth_ff; bit_buffer_in = bit_buffer_ff;
      bits_held_in = bits_held_ff; group_seen_in = group_seen_ff;
      discard_in = discard_ff; code_width_in = code_width_ff;
      next_free_in = next_free_ff; prev_code_in = prev_code_ff;
      first_char_in = first_char_ff; f_first_in = f_first_ff;
      f_clear_in = f_clear_ff; f_end_in = f_end_ff; f_err_in = f_err_ff;
      code_in = code_ff; walk_in = walk_ff; depth_in = depth_ff;
      init_in = init_ff; rsp_byte_in = rsp_byte_ff; rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      skip_in = skip_left_ff; deliver_in = deliver_left_ff;
      max_bits_in = max_bits_ff; block_mode_in = block_mode_ff;
      pre_we = 1'b0; pre_wa = next_free_ff[AW-1:0]; pre_wd = prev_code_ff;
      suf_we = 1'b0; suf_wa = next_free_ff[AW-1:0]; suf_wd = first_char_ff;
      stk_we = 1'b0; stk_wa = depth_ff[AW-1:0]; stk_wd = suf_rd;
      pre_ra = walk_ff; suf_ra = walk_ff;
      stk_ra = AW'(stack_depth_ff - 1'b1);
      st_sel = ST_OK; goto_finish = 1'b0; goto_resp = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            // write literal suffix entries
            suf_we = 1'b1; suf_wa = AW'(init_ff); suf_wd = init_ff[7:0];
            init_in = init_ff + 9'd1;
         end
         S_IDLE: if (accept) begin
            rsp_byte_in = 8'd0; rsp_valid_in = 1'b0; rsp_status_in = ST_OK;
            priority if (bad_bits || f_err_ff) rsp_status_in = ST_ERROR;
            else if (deliver_left_ff == 32'd0) rsp_status_in = ST_FINISHED;
            else if (cmd == CMD_PULL) begin
               if (stack_depth_ff != '0) stack_depth_in = stack_depth_ff - 1'b1;
               else if (f_end_ff) begin
                  if (f_first_ff || f_clear_ff) begin
                     f_err_in = 1'b1; rsp_status_in = ST_ERROR;
                  end else rsp_status_in = ST_FINISHED;
               end else rsp_status_in = ST_NEED_IN;
            end else if (stack_depth_ff != '0 || f_end_ff) begin
               rsp_status_in = ST_REJECT;
            end else begin
               if (last) f_end_in = 1'b1;
               if (discard_ff != '0) discard_in = discard_ff - 1'b1;
               else begin
                  group_seen_in = (group_seen_ff + 5'd1 >= code_width_ff)
                                  ? 5'd0 : group_seen_ff + 5'd1;
                  if (held_sum >= {1'b0, code_width_ff}) begin
                     code_in = CW'(shifted) & code_mask;
                     bit_buffer_in = 24'(shifted >> code_width_ff);
                     bits_held_in = 5'(held_sum - {1'b0, code_width_ff});
                  end else begin
                     bit_buffer_in = shifted[23:0];
                     bits_held_in = held_sum[4:0];
                  end
               end
               // early end check when no code decodes this word
               if (!(discard_ff == '0 && held_sum >= {1'b0, code_width_ff})
                   && last && (f_first_ff || f_clear_ff)) begin
                  f_err_in = 1'b1; stack_depth_in = '0;
                  rsp_status_in = ST_ERROR;
               end
            end
         end
         S_PULL_RD: begin
            if (skip_left_ff != 32'd0) skip_in = skip_left_ff - 32'd1;
            else begin
               rsp_byte_in = stk_rd; rsp_valid_in = 1'b1;
               deliver_in = deliver_left_ff - 32'd1;
            end
         end
         S_DECODE: begin
            depth_in = '0;
            walk_in = code_ff[AW-1:0];
            priority if (f_first_ff) begin
               goto_resp = 1'b1;
               if (code_ff >= CW'(LITERALS)) begin
                  f_err_in = 1'b1; stack_depth_in = '0;
               end else begin
                  stk_we = 1'b1; stk_wa = '0; stk_wd = code_ff[7:0];
                  stack_depth_in = CW'(1); first_char_in = code_ff[7:0];
                  prev_code_in = code_ff[AW-1:0]; f_first_in = 1'b0;
               end
            end else if (block_mode_ff && code_ff == CW'(LITERALS) && !f_clear_ff) begin
               goto_resp = 1'b1;
               discard_in = (group_seen_in != '0) ? code_width_ff - group_seen_in : 5'd0;
               group_seen_in = '0; bit_buffer_in = '0; bits_held_in = '0;
               code_width_in = 5'(INIT_WIDTH); next_free_in = CW'(LITERALS);
               f_clear_in = 1'b1;
            end else if (code_ff > next_free_ff ||
                         (code_ff == next_free_ff && {1'b0, next_free_ff} >= maxmax)) begin
               goto_resp = 1'b1; f_err_in = 1'b1; stack_depth_in = '0;
            end else if (code_ff == next_free_ff) begin
               stk_we = 1'b1; stk_wa = '0; stk_wd = first_char_ff;
               depth_in = CW'(1); walk_in = prev_code_ff;
            end
            // walk pointer read issued next cycle from walk_in
         end
         S_WALK_RD: ;
         S_WALK: begin
            if ({1'b0, walk_ff} >= CW'(LITERALS)) begin
               if (depth_ff >= CW'(TSIZE - 1)) begin
                  goto_resp = 1'b1; f_err_in = 1'b1; stack_depth_in = '0;
               end else begin
                  stk_we = 1'b1; stk_wd = suf_rd;
                  depth_in = depth_ff + 1'b1; walk_in = pre_rd;
               end
            end else begin
               // chain end: walk holds a literal
               goto_finish = 1'b1;
               stk_we = 1'b1; stk_wd = suf_rd;
               first_char_in = suf_rd; stack_depth_in = depth_ff + 1'b1;
            end
         end
         S_FINISH: begin
            if ({1'b0, next_free_ff} < maxmax) begin
               pre_we = 1'b1; suf_we = 1'b1;
               next_free_in = next_free_ff + 1'b1;
            end
            prev_code_in = code_ff[AW-1:0]; f_clear_in = 1'b0;
            if (code_width_ff < limit &&
                {1'b0, next_free_in} > (((CW+1)'(1) << code_width_ff) - 1'b1)) begin
               discard_in = (group_seen_ff != '0) ? code_width_ff - group_seen_ff : 5'd0;
               group_seen_in = '0; bit_buffer_in = '0; bits_held_in = '0;
               code_width_in = code_width_ff + 5'd1;
            end
         end
         S_RESP: ;
         default: ;
      endcase
      // end-of-stream check after a decode settles
      if ((goto_resp && state_ff != S_WALK) || state_ff == S_FINISH) begin
         if (!f_err_in && f_end_ff && (f_first_in || f_clear_in)) begin
            f_err_in = 1'b1; stack_depth_in = '0;
         end
         rsp_status_in = f_err_in ? ST_ERROR : ST_OK;
      end
      if (goto_resp && state_ff == S_WALK) rsp_status_in = ST_ERROR;
      // register writes must arrive only while idle; the block does not enforce it
      if (csr_we) begin
         unique case (csr_index)
            REG_MAX_BITS:   max_bits_in = csr_wdata[4:0];
            REG_BLOCK_MODE: begin
               block_mode_in = csr_wdata[0];
               if (f_first_ff)
                  next_free_in = csr_wdata[0] ? CW'(FIRST_FREE) : CW'(LITERALS);
            end
            REG_SKIP_COUNT: skip_in = csr_wdata;
            REG_OUT_COUNT:  deliver_in = csr_wdata;
         endcase
      end
      st_sel = rsp_status_in;
   end

   // refine the next state of the decode and walk steps
   state_type state_q;
   always_comb begin
      state_q = state_in;
      if (state_ff == S_DECODE || state_ff == S_WALK) begin
         priority if (goto_resp) state_q = S_RESP;
         else if (goto_finish) state_q = S_FINISH;
         else state_q = S_WALK_RD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; init_ff <= '0;
         max_bits_ff <= 5'(MAX_CODE_BITS); block_mode_ff <= 1'b1;
         skip_left_ff <= '0; deliver_left_ff <= '0;
         stack_depth_ff <= '0; bit_buffer_ff <= '0; bits_held_ff <= '0;
         group_seen_ff <= '0; discard_ff <= '0; code_width_ff <= 5'(INIT_WIDTH);
         next_free_ff <= CW'(FIRST_FREE); prev_code_ff <= '0; first_char_ff <= '0;
         f_first_ff <= 1'b1; f_clear_ff <= 1'b0; f_end_ff <= 1'b0; f_err_ff <= 1'b0;
      end else begin
         state_ff <= state_q; init_ff <= init_in;
         max_bits_ff <= max_bits_in; block_mode_ff <= block_mode_in;
         skip_left_ff <= skip_in; deliver_left_ff <= deliver_in;
         stack_depth_ff <= stack_depth_in; bit_buffer_ff <= bit_buffer_in;
         bits_held_ff <= bits_held_in; group_seen_ff <= group_seen_in;
         discard_ff <= discard_in; code_width_ff <= code_width_in;
         next_free_ff <= next_free_in; prev_code_ff <= prev_code_in;
         first_char_ff <= first_char_in; f_first_ff <= f_first_in;
         f_clear_ff <= f_clear_in; f_end_ff <= f_end_in; f_err_ff <= f_err_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      code_ff <= code_in; walk_ff <= walk_in; depth_ff <= depth_in;
      rsp_byte_ff <= rsp_byte_in; rsp_valid_ff <= rsp_valid_in;
      rsp_status_ff <= st_sel;
   end
endmodule
